// ----- hw/rtl/swarq_pkg.sv -----
// ---------------------------------------------------------------------------
// swarq_pkg: shared types and codes for the sliding-window arq sender
// Event codes, packet kinds, status codes, default timeout, sequencer and handshake states, slot type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swarq_pkg;

    // event codes on the func field
    localparam logic [2:0] FUNC_SYN  = 3'd0;
    localparam logic [2:0] FUNC_GET  = 3'd1;
    localparam logic [2:0] FUNC_DATA = 3'd2;
    localparam logic [2:0] FUNC_ACK  = 3'd3;
    localparam logic [2:0] FUNC_TICK = 3'd4;

    // emitted packet kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HS   = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_RETX = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REFUSED = 2'd1;
    localparam logic [1:0] STAT_DUP_ACK = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    // default retransmission period
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // handshake phase
    typedef enum logic [1:0] {
        PH_WAIT_SYN = 2'd0,
        PH_WAIT_GET = 2'd1,
        PH_XFER     = 2'd2
    } t_phase;

    // event sequencer
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_RDATA = 2'd2
    } t_ctl_state;

    // one window slot as stored in memory
    typedef struct packed {
        logic [31:0] seq;
        logic [10:0] bytes;
        logic [15:0] cref;
        logic        fin;
    } t_slot;

endpackage

`default_nettype wire

// ----- hw/rtl/sliding_window_arq_sender_core.sv -----
// ---------------------------------------------------------------------------
// sliding_window_arq_sender_core: sender side of a sliding-window arq link
// Handshake, circular window of sent chunks in a slot memory, cumulative
// acks and a periodic retransmission timer. One result beat per event beat.
// ---------------------------------------------------------------------------
// an event beat is captured, evaluated in ST_EXEC and loaded into the result register;
// a retransmission reads the head slot in ST_EXEC and loads it in ST_RDATA; events
//   are handled one at a time and a resend waits on the slot memory read
// output stall holds the finished result and delays the next event
// reset is synchronous: control state clears, the slot memory is not cleared
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_arq_sender_core #(
    parameter int WINDOW_SLOTS = 32,
    parameter int CHUNK_BYTES  = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    // event channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [31:0] i_peer_seq,
    input  wire logic [31:0] i_peer_ack,
    input  wire logic [15:0] i_chunk_ref,
    input  wire logic [10:0] i_chunk_bytes,
    input  wire logic        i_final_chunk,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_packet_kind,
    output logic [31:0]      o_packet_seq,
    output logic [31:0]      o_packet_ack,
    output logic             o_packet_final,
    output logic [10:0]      o_packet_bytes,
    output logic [15:0]      o_packet_ref,
    output logic [1:0]       o_status,
    output logic             o_transfer_done
);

    import swarq_pkg::*;

    localparam int            IW       = $clog2(WINDOW_SLOTS);
    localparam logic [IW-1:0] LP_LAST  = IW'(WINDOW_SLOTS - 1);
    localparam logic [IW:0]   LP_SLOTS = (IW + 1)'(WINDOW_SLOTS);
    localparam logic [16:0]   LP_CHUNK = 17'(CHUNK_BYTES);

    // sequencer
    t_ctl_state r_state, n_state;

    // captured event beat
    logic [2:0]  r_func;
    logic [31:0] r_peer_seq;
    logic [31:0] r_peer_ack;
    logic [15:0] r_chunk_ref;
    logic [10:0] r_chunk_bytes;
    logic        r_final_chunk;

    // sender state
    logic [15:0]   r_timeout;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [31:0]   r_send_base, n_send_base;
    logic [31:0]   r_next_seq, n_next_seq;
    t_phase        r_phase, n_phase;
    logic          r_finished, n_finished;
    logic          r_timer_run, n_timer_run;
    logic [15:0]   r_timer_cnt, n_timer_cnt;

    // slot memory
    t_slot r_mem [WINDOW_SLOTS];
    t_slot r_rd_data;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [31:0] r_out_seq;
    logic [31:0] r_out_ack;
    logic        r_out_final;
    logic [10:0] r_out_bytes;
    logic [15:0] r_out_ref;
    logic [1:0]  r_out_status;
    logic        r_out_done;

    // event outcome
    logic [1:0]  c_kind;
    logic [31:0] c_seq;
    logic [31:0] c_ack;
    logic        c_final;
    logic [10:0] c_bytes;
    logic [15:0] c_ref;
    logic [1:0]  c_status;
    logic        c_write;
    t_slot       c_slot;
    logic        c_need_read;

    // helpers
    logic          in_fire;
    logic          out_free;
    logic          commit;
    logic          load_exec;
    logic          load_rdata;
    logic [15:0]   timeout_val;
    logic [IW-1:0] tail_inc;
    logic [IW-1:0] outstanding;
    logic [31:0]   ack_dist;
    logic [IW:0]   head_sum;
    logic [10:0]   sat_bytes;
    logic          win_empty;

    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign timeout_val = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    assign win_empty   = (r_head == r_tail);
    assign tail_inc    = (r_tail == LP_LAST) ? '0 : r_tail + IW'(1);
    assign outstanding = (r_tail >= r_head) ? (r_tail - r_head)
                       : IW'({1'b0, r_tail} + LP_SLOTS - {1'b0, r_head});
    assign ack_dist    = r_peer_ack - r_send_base;
    assign head_sum    = {1'b0, r_head} + {1'b0, ack_dist[IW-1:0]};
    assign sat_bytes   = ({6'd0, r_chunk_bytes} > LP_CHUNK) ? LP_CHUNK[10:0]
                                                             : r_chunk_bytes;

    // a tick that expires with packets outstanding resends the head slot
    assign c_need_read = (r_func == FUNC_TICK) && r_timer_run
                      && (r_timer_cnt <= 16'd1) && !win_empty;

    // event evaluation and next sender state
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_send_base = r_send_base;
        n_next_seq  = r_next_seq;
        n_phase     = r_phase;
        n_finished  = r_finished;
        n_timer_run = r_timer_run;
        n_timer_cnt = r_timer_cnt;
        c_kind      = KIND_NONE;
        c_seq       = '0;
        c_ack       = '0;
        c_final     = 1'b0;
        c_bytes     = '0;
        c_ref       = '0;
        c_status    = STAT_OK;
        c_write     = 1'b0;
        c_slot      = '{seq: r_next_seq, bytes: sat_bytes, cref: r_chunk_ref,
                        fin: r_final_chunk};
        unique case (r_func)
            FUNC_SYN: begin
                if (r_phase == PH_WAIT_SYN || r_phase == PH_WAIT_GET) begin
                    c_kind  = KIND_HS;
                    c_ack   = r_peer_seq + 32'd1;
                    n_phase = PH_WAIT_GET;
                end else begin
                    c_status = STAT_IGNORED;
                end
            end
            FUNC_GET: begin
                if (r_phase == PH_WAIT_GET) begin
                    n_send_base = r_peer_ack;
                    n_next_seq  = r_peer_ack;
                    n_phase     = PH_XFER;
                end else begin
                    c_status = STAT_IGNORED;
                end
            end
            FUNC_DATA: begin
                if (r_phase != PH_XFER) begin
                    c_status = STAT_IGNORED;
                end else if (r_finished || tail_inc == r_head) begin
                    c_status = STAT_REFUSED;
                end else begin
                    c_write = 1'b1;
                    if (win_empty) begin
                        n_send_base = r_next_seq;
                        n_timer_run = 1'b1;
                        n_timer_cnt = timeout_val;
                    end
                    n_next_seq = r_next_seq + 32'd1;
                    n_tail     = tail_inc;
                    c_kind     = KIND_DATA;
                    c_seq      = r_next_seq;
                    c_final    = r_final_chunk;
                    c_bytes    = sat_bytes;
                    c_ref      = r_chunk_ref;
                    if (r_final_chunk) begin
                        n_finished = 1'b1;
                    end
                end
            end
            FUNC_ACK: begin
                if (r_phase != PH_XFER) begin
                    c_status = STAT_IGNORED;
                end else if (win_empty) begin
                    c_status = STAT_DUP_ACK;
                end else if (ack_dist == 32'd0 || ack_dist[31]) begin
                    c_status = STAT_DUP_ACK;
                end else if (ack_dist >= {{(32 - IW){1'b0}}, outstanding}) begin
                    n_head      = r_tail;
                    n_send_base = r_next_seq;
                end else begin
                    n_head      = (head_sum >= LP_SLOTS) ? IW'(head_sum - LP_SLOTS)
                                                         : head_sum[IW-1:0];
                    n_send_base = r_peer_ack;
                end
            end
            FUNC_TICK: begin
                if (r_timer_run) begin
                    if (r_timer_cnt <= 16'd1) begin
                        n_timer_cnt = timeout_val;
                    end else begin
                        n_timer_cnt = r_timer_cnt - 16'd1;
                    end
                end
            end
            default: begin
                c_status = STAT_IGNORED;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (c_need_read) begin
                    n_state = ST_RDATA;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDATA: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        commit     = 1'b0;
        load_exec  = 1'b0;
        load_rdata = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_EXEC: begin
                commit    = c_need_read || out_free;
                load_exec = !c_need_read && out_free;
            end
            ST_RDATA: begin
                load_rdata = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // sequencer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // event capture
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func        <= i_func;
            r_peer_seq    <= i_peer_seq;
            r_peer_ack    <= i_peer_ack;
            r_chunk_ref   <= i_chunk_ref;
            r_chunk_bytes <= i_chunk_bytes;
            r_final_chunk <= i_final_chunk;
        end
    end

    // configuration and sender state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_send_base <= '0;
            r_next_seq  <= '0;
            r_phase     <= PH_WAIT_SYN;
            r_finished  <= 1'b0;
            r_timer_run <= 1'b0;
            r_timer_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (commit) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_send_base <= n_send_base;
                r_next_seq  <= n_next_seq;
                r_phase     <= n_phase;
                r_finished  <= n_finished;
                r_timer_run <= n_timer_run;
                r_timer_cnt <= n_timer_cnt;
            end
        end
    end

    // slot memory: write at tail on an accepted chunk, read at head on resend
    always_ff @(posedge i_clk) begin
        if (commit && c_write) begin
            r_mem[r_tail] <= c_slot;
        end
        if (r_state == ST_EXEC && c_need_read) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_exec || load_rdata) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (load_exec) begin
            r_out_kind   <= c_kind;
            r_out_seq    <= c_seq;
            r_out_ack    <= c_ack;
            r_out_final  <= c_final;
            r_out_bytes  <= c_bytes;
            r_out_ref    <= c_ref;
            r_out_status <= c_status;
            r_out_done   <= n_finished && (n_head == n_tail);
        end else if (load_rdata) begin
            r_out_kind   <= KIND_RETX;
            r_out_seq    <= r_rd_data.seq;
            r_out_ack    <= '0;
            r_out_final  <= r_rd_data.fin;
            r_out_bytes  <= r_rd_data.bytes;
            r_out_ref    <= r_rd_data.cref;
            r_out_status <= STAT_OK;
            r_out_done   <= r_finished && win_empty;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_packet_kind   = r_out_kind;
    assign o_packet_seq    = r_out_seq;
    assign o_packet_ack    = r_out_ack;
    assign o_packet_final  = r_out_final;
    assign o_packet_bytes  = r_out_bytes;
    assign o_packet_ref    = r_out_ref;
    assign o_status        = r_out_status;
    assign o_transfer_done = r_out_done;

endmodule

`default_nettype wire
